[rtl/assert_macros.svh]
// assertion macros shared by the rtl, left empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

[rtl/bfci_pkg.sv]
// shared types and constants of the bloom filter check-and-insert engine
package bfci_pkg;

    // default sizing
    localparam int DEF_FILTER_BITS = 65536;
    localparam int DEF_MAX_HASHES  = 16;

    // field widths
    localparam int DIGEST_W   = 64;
    localparam int RED_CNT_W  = 6;
    localparam int CMD_W      = 2;
    localparam int BC_W       = 17;
    localparam int HC_CFG_W   = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [BC_W-1:0]     BIT_COUNT_RST  = 17'h10000;
    localparam logic [HC_CFG_W-1:0] HASH_COUNT_RST = 5'd7;

    // register index, taken from paddr bit 2
    localparam logic REG_BIT_COUNT  = 1'b0;
    localparam logic REG_HASH_COUNT = 1'b1;

    // request commands
    localparam logic [CMD_W-1:0] CMD_QUERY        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK_INSERT = 2'd2;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_ADD,
        ST_WRAP,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

[rtl/bloom_filter_check_and_insert.sv]
// bloom filter membership engine with double hashing over a cleared bit memory
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   cmd, digest_low, digest_high, key_empty
//   rsp      out        rsp_valid / rsp_stall   hit_or_new
//   cfg      in         apb psel/penable/pready bit_count at 0x0, hash_count at 0x4
//
// a request first runs a bit-serial reduction of h1, h2 and 2^64 modulo bit_count, then
// per probe the states ADD, WRAP, READ and CHECK for the index step, wrap correction and
// one memory read-modify-write, repeated for the effective hash count of probes.
// after reset a clearing pass writes one bit per cycle to every bit, with req stalled.
// the response register lets the next request start while a result waits on rsp_stall.
`include "assert_macros.svh"

module bloom_filter_check_and_insert
    import bfci_pkg::*;
#(
    parameter int FILTER_BITS = DEF_FILTER_BITS,
    parameter int MAX_HASHES  = DEF_MAX_HASHES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [DIGEST_W-1:0]   digest_low,
    input  logic [DIGEST_W-1:0]   digest_high,
    input  logic                  key_empty,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  hit_or_new,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W  = $clog2(FILTER_BITS);
    localparam int M_W    = IDX_W + 1;
    localparam int CMP_W  = (M_W > BC_W) ? M_W : BC_W;
    localparam int HC_W   = $clog2(MAX_HASHES + 1);
    localparam int HCMP_W = (HC_W > HC_CFG_W) ? HC_W : HC_CFG_W;

    // one restoring division step: shift in a bit, subtract the modulus if it fits
    function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] r,
                                                  input logic b,
                                                  input logic [M_W-1:0] m);
        logic [M_W-1:0] s;
        s = {r, b};
        if (s >= m)
        begin
            s = s - m;
        end
        return s[IDX_W-1:0];
    endfunction

    // configuration registers
    logic [BC_W-1:0]     bit_count_reg;
    logic [HC_CFG_W-1:0] hash_count_reg;

    // control state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clear_cnt_reg;
    logic [RED_CNT_W-1:0] red_cnt_reg;
    logic [HC_W-1:0]      left_reg;
    logic                 rsp_valid_reg;

    // request payload and working values
    logic [CMD_W-1:0]     cmd_reg;
    logic [DIGEST_W-1:0]  h1_reg;
    logic [DIGEST_W-1:0]  h2_reg;
    logic                 empty_reg;
    logic [M_W-1:0]       m_reg;
    logic [IDX_W-1:0]     r1_reg;
    logic [IDX_W-1:0]     r2_reg;
    logic [IDX_W-1:0]     rc_reg;
    logic [DIGEST_W-1:0]  v_reg;
    logic                 carry_reg;
    logic [IDX_W-1:0]     t_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 all_set_reg;
    logic                 any_clear_reg;
    logic                 hit_or_new_reg;

    // bit memory
    logic                 filter_mem [FILTER_BITS];
    logic                 rd_data_reg;

    // combinational helpers
    logic                 req_xfer;
    logic                 rsp_load;
    logic                 cfg_write;
    logic                 skip;
    logic                 clear_last;
    logic                 red_last;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic                 mem_wdata;
    logic [CMP_W-1:0]     bc_ext;
    logic [CMP_W-1:0]     m_sat;
    logic [M_W-1:0]       m_eff;
    logic [HCMP_W-1:0]    hc_ext;
    logic [HCMP_W-1:0]    hc_sat;
    logic [HC_W-1:0]      n_eff;
    logic [DIGEST_W:0]    v_sum;
    logic [M_W-1:0]       t_sum;
    logic [M_W-1:0]       wrap_sum;
    logic [IDX_W-1:0]     wrap_idx;
    logic [IDX_W-1:0]     r1_step;
    logic                 result;

    // effective modulus and probe count from the registers
    always_comb
    begin
        bc_ext = CMP_W'(bit_count_reg);
        if (bc_ext == '0)
        begin
            m_sat = CMP_W'(1);
        end
        else if (bc_ext > CMP_W'(FILTER_BITS))
        begin
            m_sat = CMP_W'(FILTER_BITS);
        end
        else
        begin
            m_sat = bc_ext;
        end
        m_eff = m_sat[M_W-1:0];

        hc_ext = HCMP_W'(hash_count_reg);
        if (hc_ext > HCMP_W'(MAX_HASHES))
        begin
            hc_sat = HCMP_W'(MAX_HASHES);
        end
        else
        begin
            hc_sat = hc_ext;
        end
        n_eff = hc_sat[HC_W-1:0];
    end

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_BIT_COUNT:  prdata = APB_DATA_W'(bit_count_reg);
            REG_HASH_COUNT: prdata = APB_DATA_W'(hash_count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= BIT_COUNT_RST;
            hash_count_reg <= HASH_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_BIT_COUNT:  bit_count_reg  <= pwdata[BC_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= pwdata[HC_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // request decode
    assign req_xfer   = req_valid && !req_stall;
    assign skip       = key_empty || (n_eff == '0) ||
                        !(cmd == CMD_QUERY || cmd == CMD_INSERT || cmd == CMD_CHECK_INSERT);
    assign clear_last = (clear_cnt_reg == IDX_W'(FILTER_BITS - 1));
    assign red_last   = (red_cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = skip ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (red_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:   state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                state_next = (left_reg == HC_W'(1)) ? ST_DONE : ST_ADD;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        rsp_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clear_cnt_reg;
                mem_wdata = 1'b0;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_CHECK:
            begin
                mem_we = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_CHECK_INSERT);
            end
            ST_DONE:
            begin
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clear_cnt_reg <= clear_cnt_reg + IDX_W'(1);
        end
    end

    // reduction bit counter and probes left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cnt_reg <= '0;
            left_reg    <= '0;
        end
        else
        begin
            if (req_xfer)
            begin
                red_cnt_reg <= RED_CNT_W'(DIGEST_W - 1);
                left_reg    <= n_eff;
            end
            else
            begin
                if (state_reg == ST_REDUCE)
                begin
                    red_cnt_reg <= red_cnt_reg - RED_CNT_W'(1);
                end
                if (state_reg == ST_CHECK)
                begin
                    left_reg <= left_reg - HC_W'(1);
                end
            end
        end
    end

    // probe arithmetic: 64-bit running value for the wrap carry, narrow index mod m
    assign v_sum    = {1'b0, v_reg} + {1'b0, h2_reg};
    assign t_sum    = M_W'(idx_reg) + M_W'(r2_reg);
    assign wrap_sum = M_W'(t_reg) + m_reg - M_W'(rc_reg);
    assign wrap_idx = (t_reg >= rc_reg) ? (t_reg - rc_reg) : wrap_sum[IDX_W-1:0];
    assign r1_step  = mod_step(r1_reg, h1_reg[red_cnt_reg], m_reg);

    // request payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            cmd_reg       <= cmd;
            h1_reg        <= digest_low;
            h2_reg        <= digest_high;
            empty_reg     <= key_empty;
            m_reg         <= m_eff;
            r1_reg        <= '0;
            r2_reg        <= '0;
            rc_reg        <= (m_eff == M_W'(1)) ? IDX_W'(0) : IDX_W'(1);
            all_set_reg   <= 1'b1;
            any_clear_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_REDUCE:
                begin
                    r1_reg <= r1_step;
                    r2_reg <= mod_step(r2_reg, h2_reg[red_cnt_reg], m_reg);
                    rc_reg <= mod_step(rc_reg, 1'b0, m_reg);
                    if (red_last)
                    begin
                        // probe zero: value h1, index h1 mod m
                        v_reg   <= h1_reg;
                        idx_reg <= r1_step;
                    end
                end
                ST_ADD:
                begin
                    v_reg     <= v_sum[DIGEST_W-1:0];
                    carry_reg <= v_sum[DIGEST_W];
                    t_reg     <= (t_sum >= m_reg) ? IDX_W'(t_sum - m_reg)
                                                  : t_sum[IDX_W-1:0];
                end
                ST_WRAP:
                begin
                    // an overflow past 2^64 drops 2^64 mod m from the index
                    idx_reg <= carry_reg ? wrap_idx : t_reg;
                end
                ST_CHECK:
                begin
                    all_set_reg   <= all_set_reg & rd_data_reg;
                    any_clear_reg <= any_clear_reg | ~rd_data_reg;
                end
                default: ;
            endcase
        end
    end

    // bit memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            filter_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= filter_mem[idx_reg];
    end

    // result of the finished request
    always_comb
    begin
        result = 1'b0;
        if (!empty_reg)
        begin
            case (cmd_reg)
                CMD_QUERY:        result = all_set_reg;
                CMD_CHECK_INSERT: result = any_clear_reg;
                default:          result = 1'b0;
            endcase
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            hit_or_new_reg <= result;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign hit_or_new = hit_or_new_reg;

    // checks
    `ASSERT_PROP(a_req_starts_work, (req_valid && !req_stall) |=> (state_reg != ST_IDLE), "request transfer did not start work")
    `ASSERT_PROP(a_idx_below_mod, (state_reg == ST_READ) |-> ({1'b0, idx_reg} < m_reg), "probe index not reduced below bit count")
    `ASSERT_PROP(a_rsp_from_done, $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE), "response raised outside completion")
    `ASSERT_NEVER(a_no_empty_probe, ((state_reg == ST_ADD) || (state_reg == ST_CHECK)) && (left_reg == '0), "probe with no probes left")

endmodule

[sim/tb_top.sv]
// self-checking testbench for the bloom filter check-and-insert engine
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bfci_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned TAIL_CYCLES = 300;
    localparam int unsigned POOL_SIZE   = 48;
    localparam int unsigned RANDOM_ITEMS = 2000;

    // command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_BIT_COUNT  = {REG_BIT_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_HASH_COUNT = {REG_HASH_COUNT, 2'b00};

    localparam logic [DIGEST_W-1:0] ALL_ONES = {DIGEST_W{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [CMD_W-1:0]      cmd = CMD_QUERY;
    logic [DIGEST_W-1:0]   digest_low = '0;
    logic [DIGEST_W-1:0]   digest_high = '0;
    logic                  key_empty = 1'b0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  hit_or_new;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // filter image and register copies kept by the testbench
    bit                    filter_image [DEF_FILTER_BITS];
    logic [BC_W-1:0]       cfg_bit_count  = BIT_COUNT_RST;
    logic [HC_CFG_W-1:0]   cfg_hash_count = HASH_COUNT_RST;

    // outcomes still to come out of the response channel, oldest first
    logic                  expected_hits [$];

    logic [DIGEST_W-1:0]   pool_low  [POOL_SIZE];
    logic [DIGEST_W-1:0]   pool_high [POOL_SIZE];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned stall_hold  = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned ones_seen     = 0;
    int unsigned reg_writes    = 0;
    int unsigned drains        = 0;
    logic        oldest_hit;

    bloom_filter_check_and_insert dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .digest_low  (digest_low),
        .digest_high (digest_high),
        .key_empty   (key_empty),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit_or_new  (hit_or_new),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver back-pressure, with the odd long stall
    always @(negedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
            rsp_stall  <= 1'b1;
        end
        else if (rx_idle_pct != 0 && $urandom_range(999) == 0)
        begin
            stall_hold <= $urandom_range(300, 50);
            rsp_stall  <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen <= results_seen + 1;
            if (hit_or_new === 1'b1)
                ones_seen <= ones_seen + 1;
            if (expected_hits.size() == 0)
            begin
                $error("unexpected transfer on response channel, hit_or_new %0b", hit_or_new);
                mismatches++;
            end
            else
            begin
                oldest_hit = expected_hits.pop_front();
                if (hit_or_new !== oldest_hit)
                begin
                    $error("hit_or_new mismatch: expected %0b, actual %0b",
                           oldest_hit, hit_or_new);
                    mismatches++;
                end
            end
        end
    end

    // expected outcome of one request, updating the filter image as the block would
    function automatic logic filter_outcome(input logic [CMD_W-1:0] op,
                                            input logic [DIGEST_W-1:0] h1,
                                            input logic [DIGEST_W-1:0] h2,
                                            input logic empty);
        int unsigned   modulus;
        int unsigned   probes;
        int unsigned   slot [DEF_MAX_HASHES];
        logic [DIGEST_W-1:0] sum;
        logic          all_set;

        modulus = (cfg_bit_count == 0) ? 1 : int'(cfg_bit_count);
        if (modulus > DEF_FILTER_BITS)
            modulus = DEF_FILTER_BITS;
        probes = (cfg_hash_count > DEF_MAX_HASHES) ? DEF_MAX_HASHES : int'(cfg_hash_count);

        all_set = 1'b1;
        for (int unsigned k = 1; k <= probes; k++)
        begin
            sum = h1 + h2 * DIGEST_W'(k);
            slot[k-1] = int'(sum % DIGEST_W'(modulus));
            if (!filter_image[slot[k-1]])
                all_set = 1'b0;
        end

        if (empty || op == CMD_UNUSED)
            return 1'b0;
        if (op == CMD_QUERY)
            return all_set;
        if (op == CMD_CHECK_INSERT && all_set)
            return 1'b0;
        for (int unsigned k = 0; k < probes; k++)
            filter_image[slot[k]] = 1'b1;
        return (op == CMD_CHECK_INSERT);
    endfunction

    // random digest half, leaning now and then on edge values
    function automatic logic [DIGEST_W-1:0] random_digest();
        case ($urandom_range(15))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return DIGEST_W'($urandom_range(255));
            3:       return ALL_ONES - DIGEST_W'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one request transfer, with an optional idle gap in front
    task automatic send_request(input logic [CMD_W-1:0] op,
                                input logic [DIGEST_W-1:0] h1,
                                input logic [DIGEST_W-1:0] h2,
                                input logic empty);
        int unsigned gap;

        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (tx_idle_pct != 0 && $urandom_range(7) == 0)
            gap += $urandom_range(130);
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid   <= 1'b1;
        cmd         <= op;
        digest_low  <= h1;
        digest_high <= h2;
        key_empty   <= empty;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        expected_hits.push_back(filter_outcome(op, h1, h2, empty));
        requests_sent++;
    endtask

    // hold off the request side until every outstanding result has been seen
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        drains++;
    endtask

    // register write followed by a read-back
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;

        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (addr == ADDR_BIT_COUNT)
        begin
            cfg_bit_count = value[BC_W-1:0];
            readback = APB_DATA_W'(cfg_bit_count);
        end
        else
        begin
            cfg_hash_count = value[HC_CFG_W-1:0];
            readback = APB_DATA_W'(cfg_hash_count);
        end
        reg_writes++;

        // read the register back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== readback)
        begin
            $error("prdata mismatch at 0x%0h: expected %0h, actual %0h", addr, readback, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_filter_shape(input int unsigned bits, input int unsigned hashes);
        drain_results();
        write_register(ADDR_BIT_COUNT, APB_DATA_W'(bits));
        write_register(ADDR_HASH_COUNT, APB_DATA_W'(hashes));
    endtask

    // commands, empty keys and edge digests with the reset shape
    task automatic test_commands_at_reset_shape();
        logic [DIGEST_W-1:0] k_lo;
        logic [DIGEST_W-1:0] k_hi;

        k_lo = {$urandom, $urandom};
        k_hi = {$urandom, $urandom};
        // zero digest: every probe lands on bit 0
        send_request(CMD_QUERY, '0, '0, 1'b0);
        send_request(CMD_INSERT, '0, '0, 1'b0);
        send_request(CMD_QUERY, '0, '0, 1'b0);
        send_request(CMD_CHECK_INSERT, '0, '0, 1'b0);
        // all-ones digest, probe sums wrap round 2^64
        send_request(CMD_CHECK_INSERT, ALL_ONES, ALL_ONES, 1'b0);
        send_request(CMD_QUERY, ALL_ONES, ALL_ONES, 1'b0);
        send_request(CMD_QUERY, ALL_ONES, 64'd1, 1'b0);
        // empty key and unused command leave the filter alone
        send_request(CMD_INSERT, k_lo, k_hi, 1'b1);
        send_request(CMD_QUERY, k_lo, k_hi, 1'b0);
        send_request(CMD_CHECK_INSERT, k_lo, k_hi, 1'b1);
        send_request(CMD_QUERY, k_lo, k_hi, 1'b1);
        send_request(CMD_UNUSED, k_lo, k_hi, 1'b0);
        send_request(CMD_QUERY, k_lo, k_hi, 1'b0);
        send_request(CMD_CHECK_INSERT, k_lo, k_hi, 1'b0);
        send_request(CMD_QUERY, k_lo, k_hi, 1'b0);
        // top bit of h1 alone, step of one
        send_request(CMD_INSERT, 64'h8000_0000_0000_0000, 64'd1, 1'b0);
        send_request(CMD_QUERY, 64'h8000_0000_0000_0000, 64'd1, 1'b0);
    endtask

    // zero and oversized register values
    task automatic test_register_extremes();
        logic [DIGEST_W-1:0] k_lo;
        logic [DIGEST_W-1:0] k_hi;

        // zero bit count acts as one bit
        set_filter_shape(0, DEF_MAX_HASHES);
        send_request(CMD_INSERT, random_digest(), random_digest(), 1'b0);
        send_request(CMD_QUERY, random_digest(), random_digest(), 1'b0);
        // oversized values saturate
        set_filter_shape((1 << BC_W) - 1, (1 << HC_CFG_W) - 1);
        k_lo = {$urandom, $urandom};
        k_hi = {$urandom, $urandom};
        send_request(CMD_QUERY, k_lo, k_hi, 1'b0);
        send_request(CMD_CHECK_INSERT, k_lo, k_hi, 1'b0);
        send_request(CMD_QUERY, k_lo, k_hi, 1'b0);
        // no probes at all
        set_filter_shape(DEF_FILTER_BITS, 0);
        send_request(CMD_QUERY, k_lo, k_hi, 1'b0);
        send_request(CMD_CHECK_INSERT, random_digest(), random_digest(), 1'b0);
        send_request(CMD_INSERT, random_digest(), random_digest(), 1'b0);
        // single bit, single probe
        set_filter_shape(1, 1);
        send_request(CMD_QUERY, random_digest(), random_digest(), 1'b0);
        set_filter_shape(BIT_COUNT_RST, HASH_COUNT_RST);
    endtask

    // random traffic over two filter shapes with a given idle mix
    task automatic test_random_traffic(input int unsigned phase,
                                       input int unsigned tx_pct,
                                       input int unsigned rx_pct,
                                       input int unsigned items);
        int unsigned shape_bits   [6] = '{65536, 1000, 97, 40000, 65535, 3000};
        int unsigned shape_hashes [6] = '{7, 4, 16, 1, 12, 20};
        int unsigned slot;
        int unsigned pick;
        logic [CMD_W-1:0]    op;
        logic [DIGEST_W-1:0] h1;
        logic [DIGEST_W-1:0] h2;

        for (int unsigned s = 0; s < 2; s++)
        begin
            set_filter_shape(shape_bits[phase*2+s], shape_hashes[phase*2+s]);
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            for (int unsigned i = 0; i < items / 2; i++)
            begin
                // mostly keys seen before so that hits and repeats occur
                if ($urandom_range(9) < 7)
                begin
                    slot = $urandom_range(POOL_SIZE - 1);
                    if ($urandom_range(9) == 0)
                    begin
                        pool_low[slot]  = random_digest();
                        pool_high[slot] = random_digest();
                    end
                    h1 = pool_low[slot];
                    h2 = pool_high[slot];
                end
                else
                begin
                    h1 = random_digest();
                    h2 = random_digest();
                end
                pick = $urandom_range(99);
                if (pick < 40)
                    op = CMD_QUERY;
                else if (pick < 60)
                    op = CMD_INSERT;
                else if (pick < 95)
                    op = CMD_CHECK_INSERT;
                else
                    op = CMD_UNUSED;
                send_request(op, h1, h2, $urandom_range(19) == 0);
                if ($urandom_range(49) == 0)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        foreach (pool_low[i])
        begin
            pool_low[i]  = random_digest();
            pool_high[i] = random_digest();
        end
        tx_idle_pct = 24;
        rx_idle_pct = 63;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_commands_at_reset_shape();
        test_register_extremes();
        test_random_traffic(0, 24, 63, RANDOM_ITEMS / 3);
        test_random_traffic(1, 63, 24, RANDOM_ITEMS / 3);
        test_random_traffic(2, 0, 0, RANDOM_ITEMS / 3);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d requests over %0d register writes, %0d results checked, %0d of them ones",
                 requests_sent, reg_writes, results_seen, ones_seen);
        $display("request side held back until empty %0d times, %0d cycles in all",
                 drains, cycle_count);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
